### sv/mmcs_pkg.sv
// ----------------------------------------------------------------------------
// mmcs_pkg
// Shared widths, register indexes, reset values and the job record passed
// from the classifying front end to the stretch back end.
// ----------------------------------------------------------------------------
package mmcs_pkg;

	// Field widths
	localparam int PIX_W      = 16;
	localparam int CONF_W     = 8;
	localparam int OUT_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Product of a pixel difference and the output full scale
	localparam int PROD_W = PIX_W + OUT_W;
	// Quotient bits: eight result bits plus one overflow bit
	localparam int QBITS  = OUT_W + 1;
	localparam int STEP_W = $clog2(QBITS);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_SOURCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_MIN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_MAX    = 2'd2;

	// Reset values
	localparam logic [PIX_W-1:0] FIXED_MAX_RESET = PIX_W'(2500);
	localparam logic [PIX_W-1:0] PIX_ONES        = {PIX_W{1'b1}};
	localparam logic [PIX_W-1:0] PIX_ZERO        = {PIX_W{1'b0}};
	localparam logic [PIX_W-1:0] SPAN_ONE        = PIX_W'(1);
	localparam logic [OUT_W-1:0] OUT_MAX         = {OUT_W{1'b1}};

	// Job queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = QUEUE_AW + 1;
	localparam logic [QUEUE_CW-1:0] QUEUE_FULL = QUEUE_CW'(QUEUE_DEPTH);

	// One scale request, already classified
	typedef struct packed {
		logic             was_valid;
		logic             zero;
		logic [PIX_W-1:0] diff;
		logic [PIX_W-1:0] span;
	} job_t;

endpackage

### sv/mmcs_if.sv
// ----------------------------------------------------------------------------
// mmcs_if
// Valid/ready channels of the contrast stretch: pixel in, pixel out, config.
// ----------------------------------------------------------------------------
interface mmcs_pix_in_if;
	import mmcs_pkg::*;

	logic              valid;
	logic              ready;
	logic              action;
	logic [PIX_W-1:0]  pixel;
	logic [CONF_W-1:0] confidence;
	logic              first_of_frame;

	modport source (output valid, action, pixel, confidence, first_of_frame, input ready);
	modport sink (input valid, action, pixel, confidence, first_of_frame, output ready);
endinterface

interface mmcs_pix_out_if;
	import mmcs_pkg::*;

	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] scaled;
	logic             was_valid;

	modport source (output valid, scaled, was_valid, input ready);
	modport sink (input valid, scaled, was_valid, output ready);
endinterface

interface mmcs_cfg_if;
	import mmcs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/masked_min_max_contrast_stretch.sv
// Path of a scale request: the queue, a setup step that loads the divider,
// 9 divider steps and the output register.
// Throughput: measure requests 1 per cycle while the queue is not full; scale
// requests wait for the bit-serial divider to go idle; 4 jobs can queue ahead.
// Reset: arst_n clears control, registers to defaults, running min/max to
// all ones and zero; no clearing pass.
// ----------------------------------------------------------------------------
// masked_min_max_contrast_stretch
// Masked min/max tracking and eight-bit contrast stretch of pixel samples.
// ----------------------------------------------------------------------------
module masked_min_max_contrast_stretch (
	input  logic           clk,
	input  logic           arst_n,
	mmcs_pix_in_if.sink    pix_in,
	mmcs_pix_out_if.source pix_out,
	mmcs_cfg_if.sink       cfg
);
	import mmcs_pkg::*;

	job_t front_job;
	logic front_valid;
	logic front_ready;
	job_t back_job;
	logic back_valid;
	logic back_ready;

	// Classify requests and track min/max
	mmcs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (pix_in),
		.cfg       (cfg),
		.job       (front_job),
		.job_valid (front_valid),
		.job_ready (front_ready)
	);

	// Decouple front and back
	mmcs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_job   (front_job),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_job    (back_job)
	);

	// Divide and emit
	mmcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (back_valid),
		.job_ready (back_ready),
		.job       (back_job),
		.pix_out   (pix_out)
	);

endmodule

### sv/mmcs_front.sv
// ----------------------------------------------------------------------------
// mmcs_front
// Accept pixel requests, track running min/max for measure requests and
// turn scale requests into jobs (difference, span, zero flag) for the queue.
// ----------------------------------------------------------------------------
module mmcs_front (
	input  logic           clk,
	input  logic           arst_n,
	mmcs_pix_in_if.sink    pix_in,
	mmcs_cfg_if.sink       cfg,
	output mmcs_pkg::job_t job,
	output logic           job_valid,
	input  logic           job_ready
);
	import mmcs_pkg::*;

	logic             range_source_q;
	logic [PIX_W-1:0] fixed_min_q;
	logic [PIX_W-1:0] fixed_max_q;
	logic [PIX_W-1:0] run_min_q;
	logic [PIX_W-1:0] run_max_q;

	logic             accept;
	logic             pix_ok;
	logic [PIX_W-1:0] base_min;
	logic [PIX_W-1:0] base_max;
	logic [PIX_W-1:0] lo;
	logic [PIX_W-1:0] hi;

	// Configuration writes always land
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_source_q <= 1'b0;
			fixed_min_q    <= PIX_ZERO;
			fixed_max_q    <= FIXED_MAX_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_RANGE_SOURCE: range_source_q <= cfg.data[0];
				REG_FIXED_MIN:    fixed_min_q    <= cfg.data[PIX_W-1:0];
				REG_FIXED_MAX:    fixed_max_q    <= cfg.data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// Stall every request while the queue is full, keeping order
	assign pix_in.ready = job_ready;
	assign accept       = pix_in.valid && pix_in.ready;
	assign pix_ok       = !pix_in.confidence[0];

	// Restart tracking on first pixel of a frame
	assign base_min = pix_in.first_of_frame ? PIX_ONES : run_min_q;
	assign base_max = pix_in.first_of_frame ? PIX_ZERO : run_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q <= PIX_ONES;
			run_max_q <= PIX_ZERO;
		end else if (accept && !pix_in.action) begin
			run_min_q <= (pix_ok && pix_in.pixel < base_min) ? pix_in.pixel : base_min;
			run_max_q <= (pix_ok && pix_in.pixel > base_max) ? pix_in.pixel : base_max;
		end
	end

	// Classify scale requests
	assign lo = range_source_q ? run_min_q : fixed_min_q;
	assign hi = range_source_q ? run_max_q : fixed_max_q;

	assign job_valid     = pix_in.valid && pix_in.action;
	assign job.was_valid = pix_ok;
	assign job.zero      = !pix_ok || (pix_in.pixel < lo);
	assign job.diff      = pix_in.pixel - lo;
	assign job.span      = (hi > lo) ? (hi - lo) : SPAN_ONE;

`ifndef SYNTHESIS
	a_min_max_order: assert property (@(posedge clk) disable iff (!arst_n)
		(run_min_q <= run_max_q) || (run_min_q == PIX_ONES && run_max_q == PIX_ZERO))
		else $error("running min above running max");
`endif

endmodule

### sv/mmcs_queue.sv
// ----------------------------------------------------------------------------
// mmcs_queue
// Short job queue between front and back end so each side stalls alone.
// ----------------------------------------------------------------------------
module mmcs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  mmcs_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output mmcs_pkg::job_t pop_job
);
	import mmcs_pkg::*;

	job_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;
	logic                push;
	logic                pop;

	assign push_ready = (count_q != QUEUE_FULL);
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_job    = mem_q[rd_ptr_q];

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QUEUE_FULL)
		else $error("queue count above depth");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a push");
`endif

endmodule

### sv/mmcs_back.sv
// ----------------------------------------------------------------------------
// mmcs_back
// Stretch one job: form diff*255, divide by the span one quotient bit per
// cycle, saturate to eight bits and hold the result in the output register.
// ----------------------------------------------------------------------------
module mmcs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  mmcs_pkg::job_t job,
	mmcs_pix_out_if.source pix_out
);
	import mmcs_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]        state_q;
	logic [PROD_W-1:0] rem_q;
	logic [PROD_W-1:0] dvs_q;
	logic [QBITS-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic              was_valid_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_scaled_q;
	logic              out_was_valid_q;

	logic              take;
	logic              out_free;
	logic              load;
	logic              fits;
	logic [PROD_W-1:0] product;

	assign job_ready = (state_q == ST_IDLE);
	assign take      = job_valid && job_ready;
	assign out_free  = !out_valid_q || pix_out.ready;
	assign load      = (state_q == ST_DONE) && out_free;
	assign fits      = (rem_q >= dvs_q);

	// diff * 255 as (diff << 8) - diff
	assign product = {job.diff, {OUT_W{1'b0}}} - {{OUT_W{1'b0}}, job.diff};

	// Sequencer and divider datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_DIV;
						step_q  <= STEP_W'(QBITS - 1);
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rem_q       <= job.zero ? '0 : product;
			dvs_q       <= {job.span, {OUT_W{1'b0}}};
			quo_q       <= '0;
			was_valid_q <= job.was_valid;
		end else if (state_q == ST_DIV) begin
			if (fits) begin
				rem_q <= rem_q - dvs_q;
			end
			quo_q <= {quo_q[QBITS-2:0], fits};
			dvs_q <= {1'b0, dvs_q[PROD_W-1:1]};
		end
	end

	// Output register: load finished result, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_scaled_q    <= quo_q[QBITS-1] ? OUT_MAX : quo_q[OUT_W-1:0];
			out_was_valid_q <= was_valid_q;
		end
	end

	assign pix_out.valid     = out_valid_q;
	assign pix_out.scaled    = out_scaled_q;
	assign pix_out.was_valid = out_was_valid_q;

`ifndef SYNTHESIS
	a_zero_job: assert property (@(posedge clk) disable iff (!arst_n)
		(take && job.zero) |=> (rem_q == '0))
		else $error("zero job started with nonzero remainder");
	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q == '0) |=> (state_q == ST_DONE))
		else $error("divider did not finish after last step");
	a_load_sets_out: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q)
		else $error("loaded result not presented");
`endif

endmodule
